[sv/peak_window_agc_top_defines.svh]
// assertion macros shared by the rtl
`ifndef PEAK_WINDOW_AGC_TOP_DEFINES_SVH
`define PEAK_WINDOW_AGC_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define PWAGC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define PWAGC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define PWAGC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define PWAGC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[sv/pwagc_pkg.sv]
package pwagc_pkg;

	localparam int SAMPLE_W = 16;
	localparam int MAG_W    = SAMPLE_W + 1;
	localparam int GAIN_W   = 8;
	localparam int LEVEL_W  = 15;
	localparam int COUNT_W  = 16;
	localparam int CFG_W    = 16;
	localparam int IDX_W    = 3;
	localparam int PROD_W   = MAG_W + GAIN_W;

	localparam logic [IDX_W-1:0] REG_WINDOW_LEN   = 3'd0;
	localparam logic [IDX_W-1:0] REG_TARGET_LEVEL = 3'd1;
	localparam logic [IDX_W-1:0] REG_MAX_GAIN     = 3'd2;
	localparam logic [IDX_W-1:0] REG_MIN_GAIN     = 3'd3;
	localparam logic [IDX_W-1:0] REG_GAIN_STEP    = 3'd4;
	localparam logic [IDX_W-1:0] REG_LOAD_GAIN    = 3'd5;

	localparam logic [COUNT_W-1:0] WINDOW_LEN_RST   = 16'd1023;
	localparam logic [LEVEL_W-1:0] TARGET_LEVEL_RST = 15'd16384;
	localparam logic [GAIN_W-1:0]  MAX_GAIN_RST     = 8'd255;
	localparam logic [GAIN_W-1:0]  MIN_GAIN_RST     = 8'd1;
	localparam logic [GAIN_W-1:0]  GAIN_STEP_RST    = 8'd1;
	localparam logic [GAIN_W-1:0]  LOAD_GAIN_RST    = 8'd1;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 15'h7fff;

	typedef struct packed {
		logic [COUNT_W-1:0] window_len;
		logic [LEVEL_W-1:0] target_level;
		logic [GAIN_W-1:0]  max_gain;
		logic [GAIN_W-1:0]  min_gain;
		logic [GAIN_W-1:0]  gain_step;
	} cfg_t;

	typedef struct packed {
		logic              reload;
		logic [GAIN_W-1:0] reload_gain;
	} reload_t;

	typedef struct packed {
		logic [MAG_W-1:0]  mag;
		logic              neg;
		logic [GAIN_W-1:0] gain;
	} stage_t;

endpackage

[sv/pwagc_cfg.sv]
module pwagc_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pwagc_pkg::IDX_W-1:0]    cfg_index,
	input  logic [pwagc_pkg::CFG_W-1:0]    cfg_data,
	output pwagc_pkg::cfg_t                cfg,
	output pwagc_pkg::reload_t             rld
);

	pwagc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_len   <= pwagc_pkg::WINDOW_LEN_RST;
			cfg_q.target_level <= pwagc_pkg::TARGET_LEVEL_RST;
			cfg_q.max_gain     <= pwagc_pkg::MAX_GAIN_RST;
			cfg_q.min_gain     <= pwagc_pkg::MIN_GAIN_RST;
			cfg_q.gain_step    <= pwagc_pkg::GAIN_STEP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pwagc_pkg::REG_WINDOW_LEN:   cfg_q.window_len   <= cfg_data;
				pwagc_pkg::REG_TARGET_LEVEL: cfg_q.target_level <= cfg_data[pwagc_pkg::LEVEL_W-1:0];
				pwagc_pkg::REG_MAX_GAIN:     cfg_q.max_gain     <= cfg_data[pwagc_pkg::GAIN_W-1:0];
				pwagc_pkg::REG_MIN_GAIN:     cfg_q.min_gain     <= cfg_data[pwagc_pkg::GAIN_W-1:0];
				pwagc_pkg::REG_GAIN_STEP:    cfg_q.gain_step    <= cfg_data[pwagc_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg             = cfg_q;
	assign rld.reload      = cfg_we && (cfg_index == pwagc_pkg::REG_LOAD_GAIN);
	assign rld.reload_gain = cfg_data[pwagc_pkg::GAIN_W-1:0];

endmodule

[sv/pwagc_gain.sv]
`include "peak_window_agc_top_defines.svh"

module pwagc_gain (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pwagc_pkg::cfg_t                     cfg,
	input  pwagc_pkg::reload_t                  rld,
	input  logic                                step_en,
	input  logic signed [pwagc_pkg::SAMPLE_W-1:0] sample,
	output pwagc_pkg::stage_t                   stage
);

	localparam int GW = pwagc_pkg::GAIN_W;
	localparam int LW = pwagc_pkg::LEVEL_W;
	localparam int CW = pwagc_pkg::COUNT_W;
	localparam int MW = pwagc_pkg::MAG_W;
	localparam int PW = pwagc_pkg::PROD_W;

	logic [GW-1:0] gain_q;
	logic [LW-1:0] peak_q;
	logic [CW-1:0] count_q;

	logic          neg;
	logic [MW-1:0] mag;
	logic [PW-1:0] amp_full;
	logic [LW-1:0] amp;
	logic [LW-1:0] peak_new;
	logic          win_end;
	logic [GW:0]   up_sum;
	logic [GW:0]   dn_thr;
	logic [GW-1:0] gain_up;
	logic [GW-1:0] gain_dn;
	logic [GW-1:0] gain_new;

	always_comb begin
		neg      = sample[pwagc_pkg::SAMPLE_W-1];
		mag      = neg ? (MW'(0) - {1'b1, sample}) : {1'b0, sample};
		amp_full = PW'(mag) * PW'(gain_q);
		amp      = (amp_full > PW'(pwagc_pkg::LEVEL_MAX)) ? pwagc_pkg::LEVEL_MAX
			: amp_full[LW-1:0];
		peak_new = (amp > peak_q) ? amp : peak_q;
		win_end  = (count_q >= cfg.window_len);

		up_sum  = {1'b0, gain_q} + {1'b0, cfg.gain_step};
		gain_up = (up_sum <= {1'b0, cfg.max_gain}) ? up_sum[GW-1:0] : cfg.max_gain;
		dn_thr  = {1'b0, cfg.min_gain} + {1'b0, cfg.gain_step};
		gain_dn = ({1'b0, gain_q} >= dn_thr) ? (gain_q - cfg.gain_step) : cfg.min_gain;

		if (!win_end) begin
			gain_new = gain_q;
		end else if (peak_new < cfg.target_level) begin
			gain_new = gain_up;
		end else begin
			gain_new = gain_dn;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= pwagc_pkg::LOAD_GAIN_RST;
			peak_q  <= '0;
			count_q <= '0;
		end else if (rld.reload) begin
			gain_q  <= rld.reload_gain;
			peak_q  <= '0;
			count_q <= '0;
		end else if (step_en) begin
			gain_q <= gain_new;
			if (win_end) begin
				peak_q  <= '0;
				count_q <= '0;
			end else begin
				peak_q  <= peak_new;
				count_q <= count_q + CW'(1);
			end
		end
	end

	assign stage.mag  = mag;
	assign stage.neg  = neg;
	assign stage.gain = gain_new;

	`PWAGC_ASSERT_NEXT(a_count_inc, clk, arst_n, step_en && !win_end && !rld.reload,
		count_q == CW'($past(count_q) + CW'(1)))
	`PWAGC_ASSERT_NEXT(a_window_clear, clk, arst_n, step_en && win_end && !rld.reload,
		(peak_q == '0) && (count_q == '0))
	`PWAGC_ASSERT_NEXT(a_reload_gain, clk, arst_n, rld.reload,
		(gain_q == $past(rld.reload_gain)) && (peak_q == '0) && (count_q == '0))

endmodule

[sv/pwagc_scale.sv]
module pwagc_scale (
	input  logic                                 clk,
	input  logic                                 load,
	input  pwagc_pkg::stage_t                    stage,
	output logic signed [pwagc_pkg::SAMPLE_W-1:0] sample_out,
	output logic [pwagc_pkg::GAIN_W-1:0]          gain_now
);

	localparam int SW = pwagc_pkg::SAMPLE_W;
	localparam int PW = pwagc_pkg::PROD_W;
	localparam logic [PW-1:0] POS_LIM = PW'(16'h7fff);
	localparam logic [PW-1:0] NEG_LIM = PW'(17'h08000);

	logic [PW-1:0] prod;
	logic [SW-1:0] res;

	always_comb begin
		prod = PW'(stage.mag) * PW'(stage.gain);
		if (stage.neg) begin
			res = (prod > NEG_LIM) ? {1'b1, {(SW-1){1'b0}}} : (SW'(0) - prod[SW-1:0]);
		end else begin
			res = (prod > POS_LIM) ? {1'b0, {(SW-1){1'b1}}} : prod[SW-1:0];
		end
	end

	// result register, no reset on payload
	always_ff @(posedge clk) begin
		if (load) begin
			sample_out <= $signed(res);
			gain_now   <= stage.gain;
		end
	end

endmodule

[sv/peak_window_agc_top.sv]
// an accepted beat passes the input, stage and result registers before it is presented
// throughput: one beat per cycle unless stalled; gain/peak/count loop closes in pwagc_gain
// stall from the output ripples back through any full stages to in_stall
// reset (arst_n low, asynchronous): pipeline emptied, config registers to their defaults,
// gain to the load gain default, peak and count cleared
`include "peak_window_agc_top_defines.svh"

module peak_window_agc_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [pwagc_pkg::SAMPLE_W-1:0] sample_in,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [pwagc_pkg::SAMPLE_W-1:0] sample_out,
	output logic [pwagc_pkg::GAIN_W-1:0]          gain_now,
	input  logic                                  cfg_we,
	input  logic [pwagc_pkg::IDX_W-1:0]           cfg_index,
	input  logic [pwagc_pkg::CFG_W-1:0]           cfg_data
);

	pwagc_pkg::cfg_t    cfg;
	pwagc_pkg::reload_t rld;
	pwagc_pkg::stage_t  stage_comb;
	pwagc_pkg::stage_t  stage_s2;

	logic                                  valid_s1;
	logic signed [pwagc_pkg::SAMPLE_W-1:0] sample_s1;
	logic                                  valid_s2;
	logic                                  out_valid_q;
	logic                                  adv_out;
	logic                                  adv_s2;
	logic                                  adv_s1;

	assign adv_out  = !out_valid_q || !out_stall;
	assign adv_s2   = !valid_s2 || adv_out;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;
	assign out_valid = out_valid_q;

	pwagc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.rld       (rld)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			sample_s1 <= sample_in;
		end
	end

	pwagc_gain u_gain (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.rld     (rld),
		.step_en (valid_s1 && adv_s2),
		.sample  (sample_s1),
		.stage   (stage_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			stage_s2 <= stage_comb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= valid_s2;
		end
	end

	pwagc_scale u_scale (
		.clk        (clk),
		.load       (adv_out && valid_s2),
		.stage      (stage_s2),
		.sample_out (sample_out),
		.gain_now   (gain_now)
	);

	`PWAGC_ASSERT_IMPLY(a_no_stall_accepts, clk, arst_n, !out_stall, !in_stall)
	`PWAGC_ASSERT_NEXT(a_full_pipe_stall, clk, arst_n,
		valid_s1 && valid_s2 && out_valid_q && out_stall, valid_s1 && valid_s2)

endmodule

[tb/sv/tb_peak_window_agc_top.sv]
module tb_peak_window_agc_top;

	localparam int SAMPLE_W = pwagc_pkg::SAMPLE_W;
	localparam int GAIN_W   = pwagc_pkg::GAIN_W;
	localparam int LEVEL_W  = pwagc_pkg::LEVEL_W;
	localparam int COUNT_W  = pwagc_pkg::COUNT_W;
	localparam int CFG_W    = pwagc_pkg::CFG_W;
	localparam int IDX_W    = pwagc_pkg::IDX_W;

	localparam logic [IDX_W-1:0] REG_WINDOW_LEN   = pwagc_pkg::REG_WINDOW_LEN;
	localparam logic [IDX_W-1:0] REG_TARGET_LEVEL = pwagc_pkg::REG_TARGET_LEVEL;
	localparam logic [IDX_W-1:0] REG_MAX_GAIN     = pwagc_pkg::REG_MAX_GAIN;
	localparam logic [IDX_W-1:0] REG_MIN_GAIN     = pwagc_pkg::REG_MIN_GAIN;
	localparam logic [IDX_W-1:0] REG_GAIN_STEP    = pwagc_pkg::REG_GAIN_STEP;
	localparam logic [IDX_W-1:0] REG_LOAD_GAIN    = pwagc_pkg::REG_LOAD_GAIN;
	localparam logic [IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
	localparam logic [IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

	typedef struct {
		logic signed [SAMPLE_W-1:0] sample;
		logic [GAIN_W-1:0]          gain;
	} agc_beat_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] sample_in = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic [GAIN_W-1:0]          gain_now;
	logic                       cfg_we = 1'b0;
	logic [IDX_W-1:0]           cfg_index = '0;
	logic [CFG_W-1:0]           cfg_data = '0;

	peak_window_agc_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out),
		.gain_now   (gain_now),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// gain control state and register copies
	logic [COUNT_W-1:0] win_len;
	logic [LEVEL_W-1:0] target;
	logic [GAIN_W-1:0]  gain_max;
	logic [GAIN_W-1:0]  gain_min;
	logic [GAIN_W-1:0]  step;
	logic [GAIN_W-1:0]  gain_init;
	logic [GAIN_W-1:0]  gain;
	logic [LEVEL_W-1:0] peak;
	logic [COUNT_W-1:0] count;

	logic [SAMPLE_W-1:0] pending_samples[$];
	agc_beat_t           expected_beats[$];
	agc_beat_t           head_beat;
	int                  n_issued = 0;
	int                  n_accepted = 0;
	int                  n_errors = 0;
	int                  send_idle_pct = 0;
	int                  recv_idle_pct = 0;

	function automatic agc_beat_t agc_predict(input logic [SAMPLE_W-1:0] raw);
		logic        neg;
		int unsigned mag;
		int unsigned amp;
		int unsigned g;
		int unsigned prod;
		agc_beat_t   r;
		neg = raw[SAMPLE_W-1];
		mag = neg ? (32'h10000 - raw) : raw;
		amp = mag * gain;
		if (amp > 32767)
			amp = 32767;
		if (amp > peak)
			peak = LEVEL_W'(amp);
		if (count < win_len) begin
			count++;
		end else begin
			g = gain;
			if (peak < target) begin
				if (g + step <= gain_max)
					g = g + step;
				else
					g = gain_max;
			end else begin
				if (g >= gain_min + step)
					g = g - step;
				else
					g = gain_min;
			end
			gain = GAIN_W'(g);
			peak = '0;
			count = '0;
		end
		prod = mag * gain;
		if (neg) begin
			if (prod > 32768)
				prod = 32768;
			r.sample = SAMPLE_W'(32'h10000 - prod);
		end else begin
			if (prod > 32767)
				prod = 32767;
			r.sample = SAMPLE_W'(prod);
		end
		r.gain = gain;
		return r;
	endfunction

	function automatic void agc_set_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
		case (idx)
			REG_WINDOW_LEN:   win_len = d[COUNT_W-1:0];
			REG_TARGET_LEVEL: target = d[LEVEL_W-1:0];
			REG_MAX_GAIN:     gain_max = d[GAIN_W-1:0];
			REG_MIN_GAIN:     gain_min = d[GAIN_W-1:0];
			REG_GAIN_STEP:    step = d[GAIN_W-1:0];
			REG_LOAD_GAIN: begin
				gain_init = d[GAIN_W-1:0];
				gain = gain_init;
				peak = '0;
				count = '0;
			end
			default: ;
		endcase
	endfunction

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		agc_set_reg(idx, d);
	endtask

	task automatic queue_sample(input logic [SAMPLE_W-1:0] s);
		pending_samples.push_back(s);
		n_issued++;
	endtask

	task automatic settle();
		do
			@(posedge clk);
		while (n_accepted != n_issued || expected_beats.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	initial forever #5 clk = ~clk;

	initial begin
		#3000000;
		$display("TB_ERROR");
		$finish;
	end

	// input driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_beats.push_back(agc_predict(sample_in));
				n_accepted++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					sample_in <= pending_samples.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_beats.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected beat, sample_out %0d gain_now %0d",
					$time, sample_out, gain_now);
			end else begin
				head_beat = expected_beats.pop_front();
				if (sample_out !== head_beat.sample) begin
					n_errors++;
					$display("%0t: sample_out expected %0d actual %0d",
						$time, head_beat.sample, sample_out);
				end
				if (gain_now !== head_beat.gain) begin
					n_errors++;
					$display("%0t: gain_now expected %0d actual %0d",
						$time, head_beat.gain, gain_now);
				end
			end
		end
		out_stall <= arst_n && ($urandom_range(99) < recv_idle_pct);
	end

	initial begin
		logic [CFG_W-1:0]    wl;
		logic [CFG_W-1:0]    tl;
		logic [SAMPLE_W-1:0] s;
		int unsigned         pick;
		int unsigned         sh;
		int unsigned         mag;
		win_len = pwagc_pkg::WINDOW_LEN_RST;
		target = pwagc_pkg::TARGET_LEVEL_RST;
		gain_max = pwagc_pkg::MAX_GAIN_RST;
		gain_min = pwagc_pkg::MIN_GAIN_RST;
		step = pwagc_pkg::GAIN_STEP_RST;
		gain_init = pwagc_pkg::LOAD_GAIN_RST;
		gain = pwagc_pkg::LOAD_GAIN_RST;
		peak = '0;
		count = '0;
		send_idle_pct = 38;
		recv_idle_pct = 47;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset values, full scale both ways
		queue_sample(16'h7fff);
		queue_sample(16'h8000);
		queue_sample(16'h0000);
		queue_sample(16'hffff);
		queue_sample(16'h0001);
		settle();

		// update every sample, oversized register data
		write_reg(REG_WINDOW_LEN, 16'h0000);
		write_reg(REG_TARGET_LEVEL, 16'd100);
		write_reg(REG_MAX_GAIN, 16'hffff);
		write_reg(REG_MIN_GAIN, 16'd3);
		write_reg(REG_GAIN_STEP, 16'h0105);
		write_reg(REG_LOAD_GAIN, 16'd250);
		queue_sample(16'h0001);
		queue_sample(16'h7fff);
		queue_sample(16'h8000);
		settle();
		write_reg(REG_TARGET_LEVEL, 16'hffff);
		queue_sample(16'h0000);
		queue_sample(16'h0000);
		queue_sample(16'h0000);
		settle();

		// peak equal to target falls
		write_reg(REG_TARGET_LEVEL, 16'd100);
		write_reg(REG_GAIN_STEP, 16'd1);
		write_reg(REG_LOAD_GAIN, 16'd1);
		queue_sample(16'd100);
		queue_sample(16'd33);
		queue_sample(16'h8000);
		settle();

		// min clamp above max clamp
		write_reg(REG_MAX_GAIN, 16'd10);
		write_reg(REG_MIN_GAIN, 16'd20);
		write_reg(REG_LOAD_GAIN, 16'd15);
		queue_sample(16'h0000);
		queue_sample(16'h7fff);
		queue_sample(16'h0000);
		settle();

		// zero gain
		write_reg(REG_WINDOW_LEN, 16'd3);
		write_reg(REG_MIN_GAIN, 16'd0);
		write_reg(REG_LOAD_GAIN, 16'd0);
		write_reg(REG_TARGET_LEVEL, 16'd0);
		queue_sample(16'd1000);
		queue_sample(16'h8000);
		queue_sample(16'h7fff);
		queue_sample(16'd5);
		settle();
		write_reg(REG_UNMAPPED_LO, 16'h1234);
		write_reg(REG_UNMAPPED_HI, 16'hffff);

		// window shortened below the running count
		write_reg(REG_TARGET_LEVEL, 16'd16384);
		write_reg(REG_MAX_GAIN, 16'd255);
		write_reg(REG_MIN_GAIN, 16'd1);
		write_reg(REG_WINDOW_LEN, 16'd10);
		write_reg(REG_LOAD_GAIN, 16'd5);
		repeat (6) queue_sample(16'd200);
		settle();
		write_reg(REG_WINDOW_LEN, 16'd2);
		queue_sample(16'd200);
		queue_sample(16'd200);
		settle();

		for (int ph = 0; ph < 13; ph++) begin
			if (ph == 5) begin
				send_idle_pct = 47;
				recv_idle_pct = 38;
			end
			if (ph == 10) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			pick = $urandom_range(9);
			if (ph == 1)
				wl = 16'h0000;
			else if (ph == 7)
				wl = 16'hffff;
			else if (pick < 3)
				wl = CFG_W'($urandom_range(3));
			else if (pick < 8)
				wl = CFG_W'($urandom_range(20, 4));
			else
				wl = CFG_W'($urandom_range(200, 21));
			write_reg(REG_WINDOW_LEN, wl);
			if (ph == 2)
				tl = 16'h0000;
			else if (ph == 8)
				tl = 16'hffff;
			else
				tl = CFG_W'($urandom_range(65535));
			write_reg(REG_TARGET_LEVEL, tl);
			if (ph == 4)
				write_reg(REG_MAX_GAIN, 16'd255);
			else if (ph == 9)
				write_reg(REG_MAX_GAIN, 16'd1);
			else
				write_reg(REG_MAX_GAIN, {8'($urandom_range(255)), 8'($urandom_range(255, 1))});
			if (ph == 4)
				write_reg(REG_MIN_GAIN, 16'd1);
			else if (ph == 9)
				write_reg(REG_MIN_GAIN, 16'd255);
			else if (ph == 11)
				write_reg(REG_MIN_GAIN, 16'd0);
			else
				write_reg(REG_MIN_GAIN, {8'($urandom_range(255)), 8'($urandom_range(255, 1))});
			if (ph == 4)
				write_reg(REG_GAIN_STEP, 16'd255);
			else if (ph == 6)
				write_reg(REG_GAIN_STEP, 16'd1);
			else if ($urandom_range(3) != 0)
				write_reg(REG_GAIN_STEP, CFG_W'($urandom_range(8, 1)));
			else
				write_reg(REG_GAIN_STEP, CFG_W'($urandom_range(65535)) | 16'h0001);
			if (ph == 0)
				write_reg(REG_LOAD_GAIN, 16'd255);
			else if (ph != 3)
				write_reg(REG_LOAD_GAIN, CFG_W'($urandom_range(255, 1)));
			for (int k = 0; k < 100; k++) begin
				pick = $urandom_range(19);
				if (pick < 2) begin
					case ($urandom_range(3))
						0: s = 16'h7fff;
						1: s = 16'h8000;
						2: s = 16'h0000;
						default: s = 16'hffff;
					endcase
				end else if (pick < 10) begin
					s = SAMPLE_W'($urandom_range(65535));
				end else begin
					sh = $urandom_range(14);
					mag = $urandom_range((1 << sh) - 1);
					s = SAMPLE_W'(mag);
					if ($urandom_range(1) != 0)
						s = -s;
				end
				queue_sample(s);
			end
			settle();
		end

		if (n_errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[peak_window_agc_top.f]
+incdir+sv
sv/pwagc_pkg.sv
sv/pwagc_cfg.sv
sv/pwagc_gain.sv
sv/pwagc_scale.sv
sv/peak_window_agc_top.sv
tb/sv/tb_peak_window_agc_top.sv
